@@ rtl/core/vfv_pkg.sv @@
`default_nettype none

package vfv_pkg;

    localparam int DIM_X_DEF = 32;
    localparam int DIM_Z_DEF = 32;
    localparam int DIM_Y_DEF = 32;

    localparam int COORD_W     = 5;
    localparam int CODE_W      = 8;
    localparam int MASK_W      = 6;
    localparam int MAT_W       = 3;
    // wide enough to compare a coordinate plus one against any dimension up to 511
    localparam int COORD_CMP_W = 9;

    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 16;

    localparam logic [CODE_W-1:0] CODE_AIR = 8'h41;
    localparam logic [CODE_W-1:0] CODE_D   = 8'h44;
    localparam logic [CODE_W-1:0] CODE_G   = 8'h47;
    localparam logic [CODE_W-1:0] CODE_S   = 8'h53;
    localparam logic [CODE_W-1:0] CODE_L   = 8'h4C;
    localparam logic [CODE_W-1:0] CODE_F   = 8'h46;
    localparam logic [CODE_W-1:0] CODE_B   = 8'h42;
    localparam logic [CODE_W-1:0] CODE_O   = 8'h4F;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // read sequence of a query: centre first, then one neighbour per face bit
    typedef enum logic [2:0] {
        STEP_CENTRE = 3'd0,
        STEP_ZN     = 3'd1,
        STEP_ZP     = 3'd2,
        STEP_XP     = 3'd3,
        STEP_XN     = 3'd4,
        STEP_YP     = 3'd5,
        STEP_YN     = 3'd6
    } step_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_LAST,
        ST_DONE
    } state_t;

    function automatic logic [MAT_W-1:0] material_of(input logic [CODE_W-1:0] code);
        logic [MAT_W-1:0] mat;
        unique case (code)
            CODE_D:  mat = 3'd0;
            CODE_G:  mat = 3'd1;
            CODE_S:  mat = 3'd2;
            CODE_L:  mat = 3'd3;
            CODE_F:  mat = 3'd4;
            CODE_B:  mat = 3'd5;
            CODE_O:  mat = 3'd6;
            default: mat = 3'd7;
        endcase
        return mat;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/voxel_face_visibility_top.sv @@
`default_nettype none

// Voxel face visibility core. Holds a DIM_X x DIM_Z x DIM_Y grid of 8-bit block
// codes in one single-port synchronous RAM ('A' is air). A write transaction
// (tuser = 0) stores a code in a cell inside the grid and gives no result. A
// query (tuser = 1) reads the centre cell and its six neighbours, one RAM read
// per cycle, and returns one result: visible face mask, material index and solid
// flag. The single RAM port sets the timing. There are seven read steps; a side
// on the grid edge skips its read but keeps its step. The ST_LAST state then
// folds in the last read data and ST_DONE loads the output register. The result
// shows on m_tvalid as the core returns to idle, where the next transaction is
// taken. A query outside the grid reads nothing and goes straight to ST_DONE. A
// query holds in ST_DONE while an earlier result still waits in the output
// register; its own result may still be waiting there when the next transaction
// is taken. The RAM has no reset: only cells written beforehand may be queried
// or used as neighbours.
module voxel_face_visibility_top
    import vfv_pkg::*;
#(
    parameter int DIM_X = DIM_X_DEF,
    parameter int DIM_Z = DIM_Z_DEF,
    parameter int DIM_Y = DIM_Y_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // [4:0] cell_x, [9:5] cell_z, [14:10] cell_y, [22:15] voxel_code, [23] zero
    input  wire logic [S_DATA_W-1:0] s_tdata,
    // [0] req_type
    input  wire logic                s_tuser,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // [5:0] face_mask, [8:6] material, [9] solid, [15:10] zero
    output logic [M_DATA_W-1:0]      m_tdata
);

    localparam int DEPTH  = DIM_X * DIM_Z * DIM_Y;
    localparam int ADDR_W = $clog2(DEPTH);

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [COORD_W-1:0] x,
                                                    input logic [COORD_W-1:0] z,
                                                    input logic [COORD_W-1:0] y);
        return (ADDR_W'(x) * ADDR_W'(DIM_Z) + ADDR_W'(z)) * ADDR_W'(DIM_Y) + ADDR_W'(y);
    endfunction

    function automatic logic coord_in(input logic [COORD_W-1:0] c, input int dim);
        return COORD_CMP_W'(c) < COORD_CMP_W'(dim);
    endfunction

    function automatic logic coord_top(input logic [COORD_W-1:0] c, input int dim);
        return (COORD_CMP_W'(c) + COORD_CMP_W'(1)) >= COORD_CMP_W'(dim);
    endfunction

    logic [CODE_W-1:0] mem [DEPTH];

    state_t state_reg, state_next;
    step_t  step_reg, step_next;

    logic [COORD_W-1:0] x_reg, z_reg, y_reg;
    logic               rd_vld_reg;
    step_t              rd_step_reg;
    logic               rd_edge_reg;
    logic [CODE_W-1:0]  rd_data_reg;
    logic [MASK_W-1:0]  mask_reg;
    logic [MAT_W-1:0]   mat_reg;
    logic               solid_reg;
    logic               m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;

    logic [COORD_W-1:0] in_x, in_z, in_y;
    logic [CODE_W-1:0]  in_code;
    logic               in_inside;
    logic               accept;
    logic               issue;
    logic               out_load;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [COORD_W-1:0] nx, nz, ny;
    logic               n_edge;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;

    assign in_x    = s_tdata[4:0];
    assign in_z    = s_tdata[9:5];
    assign in_y    = s_tdata[14:10];
    assign in_code = s_tdata[22:15];
    assign in_inside = coord_in(in_x, DIM_X) && coord_in(in_z, DIM_Z)
                    && coord_in(in_y, DIM_Y);

    assign accept  = s_tvalid && s_tready;
    assign wr_en   = accept && (s_tuser == REQ_WRITE) && in_inside;
    assign wr_addr = cell_addr(in_x, in_z, in_y);

    // neighbour of the current step; a side at the grid edge needs no read
    always_comb
    begin
        nx     = x_reg;
        nz     = z_reg;
        ny     = y_reg;
        n_edge = 1'b0;
        unique case (step_reg)
            STEP_CENTRE:
            begin
                n_edge = 1'b0;
            end
            STEP_ZN:
            begin
                nz     = z_reg - COORD_W'(1);
                n_edge = (z_reg == '0);
            end
            STEP_ZP:
            begin
                nz     = z_reg + COORD_W'(1);
                n_edge = coord_top(z_reg, DIM_Z);
            end
            STEP_XP:
            begin
                nx     = x_reg + COORD_W'(1);
                n_edge = coord_top(x_reg, DIM_X);
            end
            STEP_XN:
            begin
                nx     = x_reg - COORD_W'(1);
                n_edge = (x_reg == '0);
            end
            STEP_YP:
            begin
                ny     = y_reg + COORD_W'(1);
                n_edge = coord_top(y_reg, DIM_Y);
            end
            STEP_YN:
            begin
                ny     = y_reg - COORD_W'(1);
                n_edge = (y_reg == '0);
            end
            default:
            begin
                n_edge = 1'b1;
            end
        endcase
    end

    assign rd_addr = cell_addr(nx, nz, ny);
    assign rd_en   = issue && !n_edge;

    // next state
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                step_next = STEP_CENTRE;
                if (accept && (s_tuser == REQ_QUERY))
                begin
                    state_next = in_inside ? ST_READ : ST_DONE;
                end
            end
            ST_READ:
            begin
                if (step_reg == STEP_YN)
                begin
                    state_next = ST_LAST;
                end
                else
                begin
                    step_next = step_t'(step_reg + 3'd1);
                end
            end
            ST_LAST:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        s_tready = 1'b0;
        issue    = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_READ: issue    = 1'b1;
            ST_LAST: ;
            ST_DONE: out_load = !m_tvalid_reg || m_tready;
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= in_code;
        end
        else if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            step_reg     <= STEP_CENTRE;
            rd_vld_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            rd_vld_reg <= issue;
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg     <= in_x;
            z_reg     <= in_z;
            y_reg     <= in_y;
            mask_reg  <= '0;
            mat_reg   <= '0;
            solid_reg <= 1'b0;
        end
        else if (rd_vld_reg)
        begin
            if (rd_step_reg == STEP_CENTRE)
            begin
                solid_reg <= (rd_data_reg != CODE_AIR);
                mat_reg   <= material_of(rd_data_reg);
            end
            else
            begin
                mask_reg[3'(rd_step_reg - 3'd1)] <= rd_edge_reg || (rd_data_reg == CODE_AIR);
            end
        end
        if (issue)
        begin
            rd_step_reg <= step_reg;
            rd_edge_reg <= n_edge;
        end
        if (out_load)
        begin
            // an air or outside cell reports nothing
            m_tdata_reg <= {6'd0, solid_reg,
                            solid_reg ? mat_reg : MAT_W'(0),
                            solid_reg ? mask_reg : MASK_W'(0)};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg |-> $past(state_reg == ST_READ))
        else $error("read data returned without a read issue");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LAST) |-> (rd_vld_reg && rd_step_reg == STEP_YN))
        else $error("query sequence ended before the last neighbour");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the done state");

    assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !rd_en)
        else $error("memory read issued while taking a transaction");

endmodule

`default_nettype wire

@@ tb/sv/voxel_face_checker.sv @@
`default_nettype none

module voxel_face_checker
    import vfv_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    input  wire logic                s_tready,
    // [4:0] cell_x, [9:5] cell_z, [14:10] cell_y, [22:15] voxel_code, [23] zero
    input  wire logic [S_DATA_W-1:0] s_tdata,
    // [0] req_type
    input  wire logic                s_tuser,
    input  wire logic                m_tvalid,
    input  wire logic                m_tready,
    // [5:0] face_mask, [8:6] material, [9] solid, [15:10] zero
    input  wire logic [M_DATA_W-1:0] m_tdata,
    output int                       mismatches,
    output int                       results_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CELLS = DIM_X_DEF * DIM_Z_DEF * DIM_Y_DEF;
    localparam int MAX_REPORTS = 10;

    localparam int FACE_ZN = 0;
    localparam int FACE_ZP = 1;
    localparam int FACE_XP = 2;
    localparam int FACE_XN = 3;
    localparam int FACE_YP = 4;
    localparam int FACE_YN = 5;

    typedef enum logic [MAT_W-1:0] {
        MAT_D,
        MAT_G,
        MAT_S,
        MAT_L,
        MAT_F,
        MAT_B,
        MAT_O,
        MAT_OTHER
    } material_t;

    // first member lands in the top bits, so this matches m_tdata[9:0]
    typedef struct packed {
        logic             solid;
        logic [MAT_W-1:0] material;
        logic [MASK_W-1:0] face_mask;
    } face_report_t;

    logic [CODE_W-1:0] voxel_copy [CELLS];
    face_report_t      expected_faces [$];

    function automatic int cell_addr(int x, int z, int y);
        return (x * DIM_Z_DEF + z) * DIM_Y_DEF + y;
    endfunction

    function automatic bit is_air(int x, int z, int y);
        return voxel_copy[cell_addr(x, z, y)] == CODE_AIR;
    endfunction

    function automatic material_t material_index(logic [CODE_W-1:0] code);
        case (code)
            CODE_D:  return MAT_D;
            CODE_G:  return MAT_G;
            CODE_S:  return MAT_S;
            CODE_L:  return MAT_L;
            CODE_F:  return MAT_F;
            CODE_B:  return MAT_B;
            CODE_O:  return MAT_O;
            default: return MAT_OTHER;
        endcase
    endfunction

    function automatic face_report_t predict_faces(int x, int z, int y);
        face_report_t      faces;
        logic [CODE_W-1:0] centre;
        faces = '0;
        // outside the grid reads as air
        if (x >= DIM_X_DEF || z >= DIM_Z_DEF || y >= DIM_Y_DEF)
            return faces;
        centre = voxel_copy[cell_addr(x, z, y)];
        if (centre == CODE_AIR)
            return faces;
        faces.face_mask[FACE_ZN] = z == 0 || is_air(x, z - 1, y);
        faces.face_mask[FACE_ZP] = z + 1 >= DIM_Z_DEF || is_air(x, z + 1, y);
        faces.face_mask[FACE_XP] = x + 1 >= DIM_X_DEF || is_air(x + 1, z, y);
        faces.face_mask[FACE_XN] = x == 0 || is_air(x - 1, z, y);
        faces.face_mask[FACE_YP] = y + 1 >= DIM_Y_DEF || is_air(x, z, y + 1);
        faces.face_mask[FACE_YN] = y == 0 || is_air(x, z, y - 1);
        faces.material = material_index(centre);
        faces.solid    = 1'b1;
        return faces;
    endfunction

    task automatic note_mismatch(input string detail);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch at %0t ns: %s", $time, detail);
    endtask

    always @(posedge clk)
    begin
        face_report_t got;
        face_report_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                if (s_tuser == REQ_WRITE)
                    voxel_copy[cell_addr(int'(s_tdata[4:0]), int'(s_tdata[9:5]),
                                         int'(s_tdata[14:10]))] = s_tdata[22:15];
                else
                    expected_faces = {expected_faces,
                        predict_faces(int'(s_tdata[4:0]), int'(s_tdata[9:5]),
                                      int'(s_tdata[14:10]))};
            end
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[9:0];
                if (expected_faces.size() == 0)
                    note_mismatch($sformatf(
                        "unexpected result face_mask=%b material=%0d solid=%0b",
                        got.face_mask, got.material, got.solid));
                else
                begin
                    want = expected_faces.pop_front();
                    if (got != want)
                        note_mismatch($sformatf(
                            {"expected face_mask=%b material=%0d solid=%0b, ",
                             "got face_mask=%b material=%0d solid=%0b"},
                            want.face_mask, want.material, want.solid,
                            got.face_mask, got.material, got.solid));
                end
            end
        end
        results_outstanding <= expected_faces.size();
    end

endmodule

`default_nettype wire

@@ tb/sv/voxel_face_visibility_top_test.sv @@
`default_nettype none

module voxel_face_visibility_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import vfv_pkg::*;

    localparam int CELLS        = DIM_X_DEF * DIM_Z_DEF * DIM_Y_DEF;
    localparam int RANDOM_ITEMS = 1430;
    localparam int SETTLE_CYCLES = 30;

    typedef struct packed {
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic [COORD_W-1:0] x;
    } cell_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic                s_tuser = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    int mismatches;
    int results_outstanding;
    int recv_stall_pct = 0;
    int send_idle_pct  = 0;
    int items_sent     = 0;

    // cells written so far; a query only goes to a cell whose neighborhood is set
    bit    cell_written [CELLS];
    cell_t ready_cells [$];

    voxel_face_visibility_top DUT (.*);

    voxel_face_checker faces_check (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
        m_tready <= $urandom_range(0, 99) >= recv_stall_pct;

    initial
    begin
        #3_000_000;
        $display("voxel_face_visibility_top test failed");
        $finish;
    end

    function automatic cell_t at(int x, int z, int y);
        cell_t c;
        c.x = x[COORD_W-1:0];
        c.z = z[COORD_W-1:0];
        c.y = y[COORD_W-1:0];
        return c;
    endfunction

    function automatic int addr_of(cell_t c);
        return (c.x * DIM_Z_DEF + c.z) * DIM_Y_DEF + c.y;
    endfunction

    // neighbor on the side named by the step; returns 0 when it lies off the grid
    function automatic bit neighbour_of(input cell_t c, input step_t s, output cell_t n);
        int x;
        int z;
        int y;
        x = c.x;
        z = c.z;
        y = c.y;
        case (s)
            STEP_ZN: z--;
            STEP_ZP: z++;
            STEP_XP: x++;
            STEP_XN: x--;
            STEP_YP: y++;
            STEP_YN: y--;
            default: ;
        endcase
        n = at(x, z, y);
        return x >= 0 && x < DIM_X_DEF && z >= 0 && z < DIM_Z_DEF
            && y >= 0 && y < DIM_Y_DEF;
    endfunction

    function automatic int pick_coord(int dim);
        int r;
        r = $urandom_range(0, 99);
        if (r < 12)
            return 0;
        if (r < 24)
            return dim - 1;
        return $urandom_range(0, dim - 1);
    endfunction

    function automatic cell_t random_cell();
        return at(pick_coord(DIM_X_DEF), pick_coord(DIM_Z_DEF), pick_coord(DIM_Y_DEF));
    endfunction

    function automatic int nudge(int v, int dim);
        int r;
        r = v + int'($urandom_range(0, 2)) - 1;
        if (r < 0)
            r = 0;
        if (r >= dim)
            r = dim - 1;
        return r;
    endfunction

    // stay close to earlier queries so neighborhoods overlap
    function automatic cell_t near_cell();
        cell_t base;
        if (ready_cells.size() == 0)
            return random_cell();
        base = ready_cells[$urandom_range(0, ready_cells.size() - 1)];
        return at(nudge(base.x, DIM_X_DEF), nudge(base.z, DIM_Z_DEF),
                  nudge(base.y, DIM_Y_DEF));
    endfunction

    function automatic logic [CODE_W-1:0] pick_code();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return CODE_AIR;
        if (r < 80)
            case ($urandom_range(0, 6))
                0:       return CODE_D;
                1:       return CODE_G;
                2:       return CODE_S;
                3:       return CODE_L;
                4:       return CODE_F;
                5:       return CODE_B;
                default: return CODE_O;
            endcase
        return CODE_W'($urandom_range(0, 255));
    endfunction

    task automatic send_item(input logic req, input cell_t c, input logic [CODE_W-1:0] code);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {1'b0, code, c};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic write_cell(input cell_t c, input logic [CODE_W-1:0] code);
        send_item(REQ_WRITE, c, code);
        cell_written[addr_of(c)] = 1'b1;
    endtask

    task automatic query_cell(input cell_t c);
        send_item(REQ_QUERY, c, CODE_W'($urandom_range(0, 255)));
    endtask

    // fill the centre and its neighbors where missing, refresh some of the rest, then query
    task automatic build_and_query(input cell_t c, input int refresh_pct);
        cell_t n;
        for (int k = STEP_CENTRE; k <= STEP_YN; k++)
            if (neighbour_of(c, step_t'(k), n)
                && (!cell_written[addr_of(n)] || $urandom_range(0, 99) < refresh_pct))
                write_cell(n, pick_code());
        query_cell(c);
        ready_cells = {ready_cells, c};
    endtask

    task automatic run_directed();
        cell_t c;
        cell_t n;
        // low corner: the z-, x- and y- faces lie on the grid edge, inner sides mixed air and solid
        write_cell(at(0, 0, 0), CODE_D);
        write_cell(at(1, 0, 0), CODE_AIR);
        write_cell(at(0, 1, 0), CODE_G);
        write_cell(at(0, 0, 1), CODE_AIR);
        query_cell(at(0, 0, 0));
        // high corner with a code outside the material table
        c = at(DIM_X_DEF - 1, DIM_Z_DEF - 1, DIM_Y_DEF - 1);
        write_cell(c, 8'hFF);
        write_cell(at(DIM_X_DEF - 2, DIM_Z_DEF - 1, DIM_Y_DEF - 1), CODE_S);
        write_cell(at(DIM_X_DEF - 1, DIM_Z_DEF - 2, DIM_Y_DEF - 1), CODE_AIR);
        write_cell(at(DIM_X_DEF - 1, DIM_Z_DEF - 1, DIM_Y_DEF - 2), 8'h00);
        query_cell(c);
        ready_cells = {ready_cells, c};
        // x = 1 with only the x- neighbor as air
        c = at(1, 5, 5);
        for (int k = STEP_CENTRE; k <= STEP_YN; k++)
        begin
            void'(neighbour_of(c, step_t'(k), n));
            write_cell(n, k == STEP_CENTRE ? CODE_O : (k == STEP_XN ? CODE_AIR : CODE_L));
        end
        query_cell(c);
        ready_cells = {ready_cells, c};
        // air centre
        write_cell(at(0, 0, 0), CODE_AIR);
        query_cell(at(0, 0, 0));
        ready_cells = {ready_cells, at(0, 0, 0)};
    endtask

    task automatic random_step();
        int    r;
        cell_t c;
        cell_t n;
        r = $urandom_range(0, 99);
        if (r < 10)
            write_cell(random_cell(), pick_code());
        else if (r < 45)
            build_and_query(near_cell(), 20);
        else if (r < 65)
            build_and_query(random_cell(), 20);
        else
        begin
            c = ready_cells[$urandom_range(0, ready_cells.size() - 1)];
            // may change one cell of a known neighborhood before asking again
            if (r < 82 && neighbour_of(c, step_t'($urandom_range(0, STEP_YN)), n))
                write_cell(n, pick_code());
            query_cell(c);
        end
    endtask

    // hold the sender until every expected result has come back
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (results_outstanding != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int first_random;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_idle_pct = 14;
        recv_stall_pct <= 87;
        run_directed();
        wait_for_results();
        first_random = items_sent;
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = phase == 0 ? 14 : (phase == 1 ? 87 : 0);
            recv_stall_pct <= phase == 0 ? 87 : (phase == 1 ? 14 : 0);
            while (items_sent < first_random + (phase + 1) * RANDOM_ITEMS / 3)
                random_step();
            wait_for_results();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && results_outstanding == 0)
            $display("voxel_face_visibility_top test passed");
        else
            $display("voxel_face_visibility_top test failed");
        $finish;
    end

endmodule

`default_nettype wire
